// File: hdl/lrs_pkg.sv
// Package for the linear resampler to 16 kHz: word types and fixed constants.
// Depends on nothing; the top level, the interpolator and the test files use it.
`timescale 1ns / 1ps
`default_nettype none
package lrs_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 18;
  localparam int FRAC_W      = 14;
  localparam int WHOLE_STEP_W = 5;
  localparam int RESULT_CNT_W = 7;

  localparam logic [FRAC_W-1:0] TARGET_RATE = 14'd16000;
  localparam logic [RATE_W-1:0] TARGET_RATE_R = 18'd16000;
  localparam logic [RATE_W-1:0] MIN_RATE = 18'd250;
  localparam logic [RESULT_CNT_W-1:0] MAX_RESULTS = 7'd64;
  localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -17'sd32768;
  localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 17'sd32767;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       chunk_last;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       run_last;
    logic                       chunk_end;
  } out_word_t;

endpackage
`default_nettype wire

// File: hdl/linear_resampler_to_16k.sv
// Top level of the linear resampler to 16 kHz: rate split, chunk sequencer
// and output register. Depends on lrs_pkg, lrs_sdiv and lrs_interp.
//
// Usage: input words (sample_in, chunk_last) arrive on in_valid/in_ready and
// 16 kHz words (sample_out, run_last, chunk_end) leave on out_valid/out_ready.
// The rate register must be written through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. A write splits the
// rate into a whole step and a fractional step, and in_ready stays low meanwhile.
// In pass-through each word is copied straight to the output register.
// Otherwise each emitted output goes through the bit-serial multiply and
// bit-serial divide of the interpolator, and the last word of a chunk first
// runs a serial division that gives the tail length.
// The first output of a word appears once the next output or the end of the
// word's run is known, so run_last can be set on the right word.
// A stalled receiver holds the output register; the sequencer waits for it
// and accepts no new word until the current one is finished.
// Reset clears the counters k, w, rem, oidx, the previous sample and sets the rate to 16000.
`timescale 1ns / 1ps
`default_nettype none
module linear_resampler_to_16k #(
  parameter int MAX_CHUNK_SAMPLES = 1048576
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire lrs_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output lrs_pkg::out_word_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [lrs_pkg::RATE_W-1:0]     cfg_wdata
);

  localparam int SW = lrs_pkg::SAMPLE_W;
  localparam int RW = lrs_pkg::RATE_W;
  localparam int FW = lrs_pkg::FRAC_W;
  localparam int QSW = lrs_pkg::WHOLE_STEP_W;
  localparam int NCW = lrs_pkg::RESULT_CNT_W;
  localparam int KW = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int WW = KW + 1;
  localparam int QW = KW + 7;
  localparam int TNW = KW + 16;
  localparam int TDW = RW + 1;
  localparam logic [KW-1:0] K_LAST = KW'(MAX_CHUNK_SAMPLES - 1);
  localparam logic [TNW-1:0] TWO_T = TNW'(32000);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PASS  = 7'b0000010,
    S_TOT   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_INTP  = 7'b0010000,
    S_PUSH  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t                st_r, st_nxt;
  logic [RW-1:0]         rate_r, rate_nxt;
  logic [RW-1:0]         work_r, work_nxt;
  logic [QSW-1:0]        qstep_r, qstep_nxt;
  logic [FW-1:0]         rstep_r, rstep_nxt;
  logic                  split_r, split_nxt;
  logic signed [SW-1:0]  x_r, x_nxt;
  logic signed [SW-1:0]  prev_r, prev_nxt;
  logic                  last_r, last_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [WW-1:0]         w_r, w_nxt;
  logic [FW-1:0]         rem_r, rem_nxt;
  logic [QW-1:0]         oidx_r, oidx_nxt;
  logic [QW-1:0]         total_r, total_nxt;
  logic [NCW-1:0]        n_r, n_nxt;
  logic signed [SW-1:0]  pend_r, pend_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic signed [SW-1:0]  new_r, new_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lrs_pkg::out_word_t    out_r, out_nxt;

  logic                  pass;
  logic [RW-1:0]         rate_eff;
  logic                  accept;
  logic                  last_in;
  logic                  out_free;
  logic                  brk;
  logic                  same;
  logic [FW:0]           remsum;
  logic                  wrap;
  logic [TNW-1:0]        tnum;
  logic                  tot_start;
  logic                  tot_done;
  logic [TNW-1:0]        tot_quo;
  logic [TDW-1:0]        tot_rmd;
  logic                  ip_start;
  logic                  ip_done;
  logic signed [SW-1:0]  ip_res;

  assign pass     = (rate_r == '0) || (rate_r == lrs_pkg::TARGET_RATE_R);
  assign rate_eff = (rate_r < lrs_pkg::MIN_RATE) ? lrs_pkg::MIN_RATE : rate_r;
  assign in_ready = (st_r == S_IDLE) && !split_r;
  assign accept   = in_valid && in_ready;
  assign last_in  = in_data.chunk_last || (k_r >= K_LAST);
  assign out_free = !out_valid_r || out_ready;
  assign same     = w_r == WW'(k_r);
  assign brk      = last_r ? ((oidx_r >= total_r) || (w_r > WW'(k_r)))
                           : (w_r >= WW'(k_r));
  assign remsum   = {1'b0, rem_r} + {1'b0, rstep_r};
  assign wrap     = remsum >= {1'b0, lrs_pkg::TARGET_RATE};
  assign tnum     = (TNW'(k_r) + TNW'(1)) * TWO_T + TNW'(rate_eff);
  assign tot_start = accept && !pass && last_in;
  assign ip_start = (st_r == S_CHK) && !brk && (n_r < lrs_pkg::MAX_RESULTS);

  lrs_sdiv #(.NW(TNW), .DW(TDW)) u_tot_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tot_start),
    .num   (tnum),
    .den   ({rate_eff, 1'b0}),
    .done  (tot_done),
    .quo   (tot_quo),
    .rmd   (tot_rmd)
  );

  lrs_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ip_start),
    .x0     (same ? x_r : prev_r),
    .x1     (x_r),
    .frac   (rem_r),
    .done   (ip_done),
    .result (ip_res)
  );

  always_comb begin
    rate_nxt  = rate_r;
    work_nxt  = work_r;
    qstep_nxt = qstep_r;
    rstep_nxt = rstep_r;
    split_nxt = split_r;
    if (cfg_we) begin
      rate_nxt  = cfg_wdata;
      work_nxt  = (cfg_wdata < lrs_pkg::MIN_RATE) ? lrs_pkg::MIN_RATE : cfg_wdata;
      qstep_nxt = '0;
      split_nxt = 1'b1;
    end else if (split_r) begin
      if (work_r >= lrs_pkg::TARGET_RATE_R) begin
        work_nxt  = work_r - lrs_pkg::TARGET_RATE_R;
        qstep_nxt = qstep_r + 1'b1;
      end else begin
        rstep_nxt = work_r[FW-1:0];
        split_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    st_nxt        = st_r;
    x_nxt         = x_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    w_nxt         = w_r;
    rem_nxt       = rem_r;
    oidx_nxt      = oidx_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt      = in_data.sample_in;
          last_nxt   = pass ? in_data.chunk_last : last_in;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          if (pass) begin
            st_nxt = S_PASS;
          end else if (last_in) begin
            st_nxt = S_TOT;
          end else begin
            st_nxt = S_CHK;
          end
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.sample_out = x_r;
          out_nxt.run_last   = 1'b1;
          out_nxt.chunk_end  = last_r;
          st_nxt             = S_IDLE;
        end
      end
      S_TOT: begin
        if (tot_done) begin
          total_nxt = tot_quo[QW-1:0];
          st_nxt    = S_CHK;
        end
      end
      S_CHK: begin
        if (brk) begin
          st_nxt = S_FLUSH;
        end else if (ip_start) begin
          st_nxt = S_INTP;
        end else begin
          oidx_nxt = oidx_r + 1'b1;
          rem_nxt  = wrap ? FW'(remsum - {1'b0, lrs_pkg::TARGET_RATE}) : remsum[FW-1:0];
          w_nxt    = w_r + WW'(qstep_r) + WW'(wrap);
        end
      end
      S_INTP: begin
        if (ip_done) begin
          new_nxt = ip_res;
          st_nxt  = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt      = 1'b1;
            out_nxt.sample_out = pend_r;
            out_nxt.run_last   = 1'b0;
            out_nxt.chunk_end  = 1'b0;
          end
          pend_nxt   = new_r;
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + 1'b1;
          oidx_nxt   = oidx_r + 1'b1;
          rem_nxt    = wrap ? FW'(remsum - {1'b0, lrs_pkg::TARGET_RATE}) : remsum[FW-1:0];
          w_nxt      = w_r + WW'(qstep_r) + WW'(wrap);
          st_nxt     = S_CHK;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt      = 1'b1;
            out_nxt.sample_out = pend_r;
            out_nxt.run_last   = 1'b1;
            out_nxt.chunk_end  = last_r;
          end
          pend_v_nxt = 1'b0;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (((st_r == S_PASS) || (st_r == S_FLUSH)) && (st_nxt == S_IDLE)) begin
      prev_nxt = x_r;
      if (last_r) begin
        k_nxt    = '0;
        w_nxt    = '0;
        rem_nxt  = '0;
        oidx_nxt = '0;
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      rate_r      <= lrs_pkg::TARGET_RATE_R;
      qstep_r     <= QSW'(1);
      rstep_r     <= '0;
      split_r     <= 1'b0;
      prev_r      <= '0;
      k_r         <= '0;
      w_r         <= '0;
      rem_r       <= '0;
      oidx_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rate_r      <= rate_nxt;
      qstep_r     <= qstep_nxt;
      rstep_r     <= rstep_nxt;
      split_r     <= split_nxt;
      prev_r      <= prev_nxt;
      k_r         <= k_nxt;
      w_r         <= w_nxt;
      rem_r       <= rem_nxt;
      oidx_r      <= oidx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    work_r  <= work_nxt;
    x_r     <= x_nxt;
    last_r  <= last_nxt;
    total_r <= total_nxt;
    n_r     <= n_nxt;
    pend_r  <= pend_nxt;
    new_r   <= new_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: hdl/lrs_sdiv.sv
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module lrs_sdiv #(
  parameter int NW = 30,
  parameter int DW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic [DW-1:0]      rmd
);

  localparam int CW = $clog2(NW + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(NW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [DW-1:0] p_r, p_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {p_r, n_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    p_nxt    = p_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      n_nxt    = num;
      p_nxt    = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      n_nxt = {n_r[NW-2:0], ge};
      p_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    p_r   <= p_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = n_r;
  assign rmd  = p_r;

endmodule
`default_nettype wire

// File: hdl/lrs_interp.sv
// Interpolator: serial shift-add multiply of the fraction by the sample step,
// serial division by the target rate, then round half to even and clamp.
// Depends on lrs_pkg and lrs_sdiv.
`timescale 1ns / 1ps
`default_nettype none
module lrs_interp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [lrs_pkg::SAMPLE_W-1:0] x0,
  input  wire logic signed [lrs_pkg::SAMPLE_W-1:0] x1,
  input  wire logic [lrs_pkg::FRAC_W-1:0]          frac,
  output logic                                     done,
  output logic signed [lrs_pkg::SAMPLE_W-1:0]      result
);

  localparam int SW = lrs_pkg::SAMPLE_W;
  localparam int FW = lrs_pkg::FRAC_W;
  localparam int PW = SW + FW;
  localparam int CW = $clog2(FW + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(FW - 1);
  localparam logic signed [SW+2:0] Y_MIN = (SW+3)'(lrs_pkg::SAMPLE_MIN);
  localparam logic signed [SW+2:0] Y_MAX = (SW+3)'(lrs_pkg::SAMPLE_MAX);

  typedef enum logic [3:0] {
    I_IDLE = 4'b0001,
    I_MUL  = 4'b0010,
    I_DIV  = 4'b0100,
    I_RND  = 4'b1000
  } istate_t;

  istate_t              st_r, st_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [SW-1:0] x0_r, x0_nxt;
  logic                 neg_r, neg_nxt;
  logic [SW-1:0]        mag_r, mag_nxt;
  logic [SW-1:0]        hi_r, hi_nxt;
  logic [FW-1:0]        lo_r, lo_nxt;
  logic signed [SW-1:0] res_r, res_nxt;
  logic                 done_r, done_nxt;
  logic                 div_start;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic [FW-1:0]        div_rmd;
  logic signed [SW:0]   d;
  logic [SW:0]          sum;
  logic signed [SW+1:0] q;
  logic [FW:0]          r;
  logic [FW+1:0]        r2;
  logic                 up;
  logic signed [SW+2:0] y;

  assign d   = {x1[SW-1], x1} - {x0[SW-1], x0};
  assign sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mag_r} : '0);

  lrs_sdiv #(.NW(PW), .DW(FW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({hi_r, lo_r}),
    .den   (lrs_pkg::TARGET_RATE),
    .done  (div_done),
    .quo   (div_quo),
    .rmd   (div_rmd)
  );

  always_comb begin
    if (!neg_r) begin
      q = {2'b00, div_quo[SW-1:0]};
      r = {1'b0, div_rmd};
    end else if (div_rmd == '0) begin
      q = -$signed({2'b00, div_quo[SW-1:0]});
      r = '0;
    end else begin
      q = -$signed({2'b00, div_quo[SW-1:0]}) - 18'sd1;
      r = {1'b0, lrs_pkg::TARGET_RATE} - {1'b0, div_rmd};
    end
    r2 = {r, 1'b0};
    up = (r2 > {2'b00, lrs_pkg::TARGET_RATE})
         || ((r2 == {2'b00, lrs_pkg::TARGET_RATE}) && (q[0] ^ x0_r[0]));
    y = {{3{x0_r[SW-1]}}, x0_r} + {q[SW+1], q} + {{(SW+2){1'b0}}, up};
  end

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    x0_nxt    = x0_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      I_IDLE: begin
        if (start) begin
          x0_nxt  = x0;
          neg_nxt = d[SW];
          mag_nxt = d[SW] ? SW'(-d) : d[SW-1:0];
          hi_nxt  = '0;
          lo_nxt  = frac;
          cnt_nxt = '0;
          st_nxt  = I_MUL;
        end
      end
      I_MUL: begin
        {hi_nxt, lo_nxt} = {sum, lo_r[FW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          st_nxt = I_DIV;
        end
      end
      I_DIV: begin
        div_start = 1'b1;
        st_nxt    = I_RND;
      end
      I_RND: begin
        if (div_done) begin
          if (y < Y_MIN) begin
            res_nxt = lrs_pkg::SAMPLE_MIN[SW-1:0];
          end else if (y > Y_MAX) begin
            res_nxt = lrs_pkg::SAMPLE_MAX[SW-1:0];
          end else begin
            res_nxt = y[SW-1:0];
          end
          done_nxt = 1'b1;
          st_nxt   = I_IDLE;
        end
      end
      default: st_nxt = I_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= I_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    x0_r  <= x0_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// File: test/lrs_checker.sv
// Checker for the linear resampler to 16 kHz: watches both word channels,
// predicts the 16 kHz output words and compares them. Depends on lrs_pkg.
`timescale 1ns / 1ps
module lrs_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  lrs_pkg::in_word_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  lrs_pkg::out_word_t         out_data,
  input  logic                       cfg_we,
  input  logic [lrs_pkg::RATE_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending_words
);

  localparam int CHUNK_MAX = 1048576;
  localparam int OUT_LIMIT = 64;

  logic [lrs_pkg::RATE_W-1:0] rate_reg;
  logic signed [15:0] prev_sample;
  int unsigned in_idx;
  int unsigned pos_whole;
  int unsigned pos_rem;
  int unsigned out_idx;
  lrs_pkg::out_word_t expected_words[$];

  initial pending_words = 0;

  function automatic logic signed [15:0] blend(int x0, int x1, int unsigned rem);
    longint num, q, r;
    num = (64'sd16000 - longint'(rem)) * x0 + longint'(rem) * x1;
    q = num / 16000;
    r = num % 16000;
    if (r < 0) begin
      q = q - 1;
      r = r + 16000;
    end
    if (2 * r > 16000 || (2 * r == 16000 && q[0])) q = q + 1;
    if (q < -32768) q = -32768;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  task automatic predict_word(lrs_pkg::in_word_t w);
    int unsigned rate, k;
    longint unsigned total;
    logic last;
    int n;
    lrs_pkg::out_word_t ow;
    rate = rate_reg;
    k = in_idx;
    n = 0;
    total = 0;
    last = w.chunk_last || k >= CHUNK_MAX - 1;
    if (rate == 0 || rate == 16000) begin
      ow.sample_out = w.sample_in;
      ow.run_last = 1'b1;
      ow.chunk_end = w.chunk_last;
      expected_words.push_back(ow);
      prev_sample = w.sample_in;
      if (w.chunk_last) begin
        in_idx = 0; pos_whole = 0; pos_rem = 0; out_idx = 0;
      end else in_idx = k + 1;
      return;
    end
    if (rate < 250) rate = 250;
    if (last) total = (longint'(k + 1) * 32000 + rate) / (2 * longint'(rate));
    forever begin
      if (last) begin
        if (longint'(out_idx) >= total || pos_whole > k) break;
      end else if (k == 0 || pos_whole > k - 1) break;
      if (n < OUT_LIMIT) begin
        ow.sample_out = (pos_whole == k) ? w.sample_in
                      : blend(prev_sample, w.sample_in, pos_rem);
        if (pos_whole == k) ow.sample_out = blend(w.sample_in, w.sample_in, pos_rem);
        ow.run_last = 1'b0;
        ow.chunk_end = 1'b0;
        expected_words.push_back(ow);
        n++;
      end
      out_idx++;
      pos_rem = pos_rem + rate;
      pos_whole = pos_whole + pos_rem / 16000;
      pos_rem = pos_rem % 16000;
    end
    if (n > 0) begin
      expected_words[$].run_last = 1'b1;
      if (last) expected_words[$].chunk_end = 1'b1;
    end
    prev_sample = w.sample_in;
    if (last) begin
      in_idx = 0; pos_whole = 0; pos_rem = 0; out_idx = 0;
    end else in_idx = k + 1;
  endtask

  always @(posedge clk) begin
    lrs_pkg::out_word_t ew;
    int errs;
    errs = 0;
    if (!rst_n) begin
      rate_reg <= 18'd16000;
      prev_sample = 0;
      in_idx = 0; pos_whole = 0; pos_rem = 0; out_idx = 0;
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) rate_reg <= cfg_wdata;
      if (in_valid && in_ready) predict_word(in_data);
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h", out_data);
          errs++;
        end else begin
          ew = expected_words.pop_front();
          if (ew.sample_out !== out_data.sample_out) begin
            $error("sample_out expected %0d actual %0d", ew.sample_out, out_data.sample_out);
            errs++;
          end
          if (ew.run_last !== out_data.run_last) begin
            $error("run_last expected %0b actual %0b", ew.run_last, out_data.run_last);
            errs++;
          end
          if (ew.chunk_end !== out_data.chunk_end) begin
            $error("chunk_end expected %0b actual %0b", ew.chunk_end, out_data.chunk_end);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending_words = expected_words.size();
  end
endmodule

// File: test/testbench.sv
// Top of the resampler test: makes clock, reset, rate writes and input words,
// stalls the receiver, and gives the verdict. Depends on lrs_pkg, lrs_checker.
`timescale 1ns / 1ps
module testbench;

  localparam int STALL_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  lrs_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  lrs_pkg::out_word_t out_data;
  logic cfg_we;
  logic [lrs_pkg::RATE_W-1:0] cfg_wdata;
  int fail_count;
  int pending_words;
  int quiet_cycles;
  bit calm_mode;
  bit hold_off;

  linear_resampler_to_16k u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lrs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, none in calm mode, and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 35);
  end

  initial begin
    hold_off = 1'b0;
    wait (calm_mode);
    repeat (20) @(posedge clk);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;
  end

  task automatic send_word(logic signed [15:0] s, logic last);
    if (!calm_mode) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= '{sample_in: s, chunk_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_rate(logic [lrs_pkg::RATE_W-1:0] r);
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_chunk(int len);
    for (int i = 0; i < len; i++) send_word(16'($urandom), i == len - 1);
  endtask

  initial begin
    int rates[9];
    rates = '{0, 8000, 48000, 192000, 100, 262143, 44100, 16000, 11025};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm_mode = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b1);
    write_rate(18'd22050);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b0);
    send_word(16'sh0001, 1'b0);
    send_word(-16'sh0001, 1'b1);
    send_word(16'sh1234, 1'b1);
    write_rate(18'd1);
    send_word(16'sh7fff, 1'b0);
    send_word(-16'sh8000, 1'b1);
    write_rate(18'd48000);
    send_word(16'sh0005, 1'b1);
    send_word(16'sh0005, 1'b0);
    send_word(-16'sh0005, 1'b1);
    foreach (rates[j]) begin
      write_rate(18'(rates[j]));
      if (j == 6) calm_mode = 1'b1;
      if (j == 7) calm_mode = 1'b0;
      for (int c = 0; c < 4; c++) begin
        if (rates[j] == 100 || rates[j] == 8000) random_chunk($urandom_range(1, 2));
        else random_chunk($urandom_range(1, 8));
      end
    end
    write_rate(18'($urandom_range(250, 192000)));
    for (int c = 0; c < 6; c++) random_chunk($urandom_range(1, 10));
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/lrs_pkg.sv
hdl/lrs_sdiv.sv
hdl/lrs_interp.sv
hdl/linear_resampler_to_16k.sv
test/lrs_checker.sv
test/testbench.sv
